### rtl/d8ct_pkg.sv
package d8ct_pkg;

  // Operation codes carried in cmd.op
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Register index, reg_addr[3:1]
  localparam logic [2:0] REG_TCR   = 3'd0;
  localparam logic [2:0] REG_TCSR  = 3'd1;
  localparam logic [2:0] REG_TCORA = 3'd2;
  localparam logic [2:0] REG_TCORB = 3'd3;
  localparam logic [2:0] REG_TCNT  = 3'd4;
  localparam logic [2:0] REG_TCCR  = 3'd5;

  // TCCR clock select, TCR clear mode
  localparam logic [1:0] CKS_INTERNAL = 2'd1;
  localparam logic [1:0] CKS_EVENT    = 2'd3;
  localparam logic [1:0] CCLR_A       = 2'd1;
  localparam logic [1:0] CCLR_B       = 2'd2;

  localparam logic [15:0] TCCR_WR_MASK = 16'h6060;
  localparam logic [7:0]  TCSR1_FIXED  = 8'h10;
  localparam logic [7:0]  COMPARE_RST  = 8'hff;
  localparam logic [15:0] ALL_ONES     = 16'hffff;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  reg_addr;
    logic        wide_access;
    logic [15:0] write_data;
  } cmd_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        access_error;
    logic        irq_match_a0;
    logic        irq_match_b0;
    logic        irq_overflow0;
    logic        irq_match_a1;
    logic        irq_match_b1;
    logic        irq_overflow1;
  } rsp_t;

  typedef struct packed {
    logic [7:0] count;
    logic       hit_a;
    logic       hit_b;
    logic       ovf;
  } step_t;

  typedef struct packed {
    logic        expire;
    logic [12:0] count;
  } presc_t;

  // Divide ratio; zero means stopped
  function automatic logic [13:0] divider(input logic [2:0] sel);
    logic [13:0] d;
    unique case (sel)
      3'd0: d = 14'd1;
      3'd1: d = 14'd2;
      3'd2: d = 14'd8;
      3'd3: d = 14'd32;
      3'd4: d = 14'd64;
      3'd5: d = 14'd1024;
      3'd6: d = 14'd8192;
      default: d = 14'd0;
    endcase
    return d;
  endfunction

  function automatic presc_t presc_tick(input logic [12:0] pc, input logic [7:0] tccr);
    presc_t      r;
    logic [13:0] div;
    logic [13:0] inc;
    div = divider(tccr[2:0]);
    inc = {1'b0, pc} + 14'd1;
    r.expire = 1'b0;
    r.count  = pc;
    if (tccr[4:3] == CKS_INTERNAL && div != 14'd0) begin
      if (inc >= div) begin
        r.expire = 1'b1;
        r.count  = '0;
      end else begin
        r.count = inc[12:0];
      end
    end
    return r;
  endfunction

  // One counter increment with clear-on-match and overflow
  function automatic step_t cnt_step(input logic [7:0] cnt, input logic [7:0] cor_a,
                                     input logic [7:0] cor_b, input logic [1:0] cclr);
    step_t      r;
    logic [8:0] n;
    n = {1'b0, cnt} + 9'd1;
    if (cclr == CCLR_A && n == {1'b0, cor_a} + 9'd1) n = '0;
    r.hit_a = (n == {1'b0, cor_a});
    if (cclr == CCLR_B && n == {1'b0, cor_b} + 9'd1) n = '0;
    r.hit_b = (n == {1'b0, cor_b});
    r.ovf   = n[8];
    r.count = n[7:0];
    return r;
  endfunction

endpackage

### rtl/dual_8bit_compare_timer.sv
// Two-channel 8-bit compare/match timer. Each cmd transfer is one timer tick,
// one register write or one register read, and each gives exactly one rsp
// transfer. One cmd is taken every clock cycle unless the output stalls; each
// response passes an input register, then a result register, and res_ready low
// stalls both stages, so cmd_ready then drops once the input register is full.
// Registers per channel (reg_addr[0] picks the channel, reg_addr[3:1] the
// register): TCR, TCSR, TCORA, TCORB, TCNT, TCCR. 16-bit access covers both
// channels with channel 0 in the high byte; a 16-bit access to TCR or TCSR is
// flagged in access_error and reads back all ones. Interrupt outputs are
// single-transfer pulses on tick responses only.
module dual_8bit_compare_timer import d8ct_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  output logic res_valid,
  input  logic res_ready,
  output rsp_t res
);

  // Pipeline: s1 holds the accepted command, res the finished response
  logic s1_valid;
  cmd_t s1;
  logic advance;

  // Timer state, one entry per channel
  logic [7:0]  tcr [2];
  logic [7:0]  tcsr [2];
  logic [7:0]  cora [2];
  logic [7:0]  corb [2];
  logic [7:0]  tcnt [2];
  logic [7:0]  tccr [2];
  logic [12:0] pcnt [2];

  logic [7:0]  tcr_next [2];
  logic [7:0]  tcsr_next [2];
  logic [7:0]  cora_next [2];
  logic [7:0]  corb_next [2];
  logic [7:0]  tcnt_next [2];
  logic [7:0]  tccr_next [2];
  logic [12:0] pcnt_next [2];
  rsp_t        res_next;

  assign advance   = s1_valid && (!res_valid || res_ready);
  assign cmd_ready = !s1_valid || !res_valid || res_ready;

  // Tick evaluation, computed from current state
  presc_t pre0, pre1;
  step_t  st0, st1;
  logic   step0, step1;

  always_comb begin
    pre0  = presc_tick(pcnt[0], tccr[0]);
    pre1  = presc_tick(pcnt[1], tccr[1]);
    st0   = cnt_step(tcnt[0], cora[0], corb[0], tcr[0][4:3]);
    st1   = cnt_step(tcnt[1], cora[1], corb[1], tcr[1][4:3]);
    // ch1 counts ch0 compare A; ch0 counts ch1 overflow (16-bit cascade).
    // Event mode excludes internal clocking, so each channel steps once.
    step1 = pre1.expire || (tccr[1][4:3] == CKS_EVENT && pre0.expire && st0.hit_a);
    step0 = pre0.expire || (tccr[0][4:3] == CKS_EVENT && step1 && st1.ovf);
  end

  // Register access decode
  logic        ch;
  logic [2:0]  idx;
  logic        wide_err;
  logic [15:0] wval;
  logic [7:0]  new0, new1;
  logic        we0, we1;
  logic [7:0]  rd0, rd1;
  logic        pair_hit;

  always_comb begin
    ch       = s1.reg_addr[0];
    idx      = s1.reg_addr[3:1];
    wide_err = s1.wide_access && (s1.reg_addr[3:2] == 2'b00);
    wval     = (idx == REG_TCCR) ? (s1.write_data & ~TCCR_WR_MASK) : s1.write_data;
    new0     = s1.wide_access ? wval[15:8] : wval[7:0];
    new1     = wval[7:0];
    we0      = s1.wide_access || !ch;
    we1      = s1.wide_access || ch;

    pair_hit = 1'b1;
    unique case (idx)
      REG_TCORA: begin rd0 = cora[0]; rd1 = cora[1]; end
      REG_TCORB: begin rd0 = corb[0]; rd1 = corb[1]; end
      REG_TCNT:  begin rd0 = tcnt[0]; rd1 = tcnt[1]; end
      REG_TCCR:  begin rd0 = tccr[0]; rd1 = tccr[1]; end
      default: begin
        rd0      = tcr[0];
        rd1      = tcr[1];
        pair_hit = 1'b0;
      end
    endcase
  end

  always_comb begin
    tcr_next  = tcr;
    tcsr_next = tcsr;
    cora_next = cora;
    corb_next = corb;
    tcnt_next = tcnt;
    tccr_next = tccr;
    pcnt_next = pcnt;
    res_next  = '0;

    unique case (s1.op)
      OP_TICK: begin
        pcnt_next[0] = pre0.count;
        pcnt_next[1] = pre1.count;
        if (step0) tcnt_next[0] = st0.count;
        if (step1) tcnt_next[1] = st1.count;
        res_next.irq_match_a0  = step0 && st0.hit_a && tcr[0][6];
        res_next.irq_match_b0  = step0 && st0.hit_b && tcr[0][7];
        res_next.irq_overflow0 = step0 && st0.ovf   && tcr[0][5];
        res_next.irq_match_a1  = step1 && st1.hit_a && tcr[1][6];
        res_next.irq_match_b1  = step1 && st1.hit_b && tcr[1][7];
        res_next.irq_overflow1 = step1 && st1.ovf   && tcr[1][5];
      end
      OP_WRITE: begin
        if (wide_err) begin
          res_next.access_error = 1'b1;
        end else begin
          unique case (idx)
            REG_TCR: tcr_next[ch] = wval[7:0];
            REG_TCSR: begin
              if (ch) tcsr_next[1] = wval[7:0] | TCSR1_FIXED;
              else    tcsr_next[0] = wval[7:0];
            end
            REG_TCORA: begin
              if (we0) cora_next[0] = new0;
              if (we1) cora_next[1] = new1;
            end
            REG_TCORB: begin
              if (we0) corb_next[0] = new0;
              if (we1) corb_next[1] = new1;
            end
            REG_TCNT: begin
              if (we0) tcnt_next[0] = new0;
              if (we1) tcnt_next[1] = new1;
            end
            REG_TCCR: begin
              if (we0) tccr_next[0] = new0;
              if (we1) tccr_next[1] = new1;
            end
            default: ;  // unimplemented: ignored
          endcase
        end
      end
      OP_READ: begin
        if (wide_err) begin
          res_next.access_error = 1'b1;
          res_next.read_data    = ALL_ONES;
        end else if (idx == REG_TCR) begin
          res_next.read_data = {8'h00, tcr[ch]};
        end else if (idx == REG_TCSR) begin
          res_next.read_data = {8'h00, tcsr[ch]};
        end else if (pair_hit) begin
          res_next.read_data = s1.wide_access ? {rd0, rd1} : {8'h00, ch ? rd1 : rd0};
        end else begin
          res_next.read_data = ALL_ONES;
        end
      end
      default: ;  // no operation, all-zero response
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
      tcr       <= '{8'h00, 8'h00};
      tcsr      <= '{8'h00, TCSR1_FIXED};
      cora      <= '{COMPARE_RST, COMPARE_RST};
      corb      <= '{COMPARE_RST, COMPARE_RST};
      tcnt      <= '{8'h00, 8'h00};
      tccr      <= '{8'h00, 8'h00};
      pcnt      <= '{13'd0, 13'd0};
    end else begin
      if (cmd_valid && cmd_ready) s1_valid <= 1'b1;
      else if (advance)           s1_valid <= 1'b0;
      if (advance)        res_valid <= 1'b1;
      else if (res_ready) res_valid <= 1'b0;
      if (advance) begin
        tcr  <= tcr_next;
        tcsr <= tcsr_next;
        cora <= cora_next;
        corb <= corb_next;
        tcnt <= tcnt_next;
        tccr <= tccr_next;
        pcnt <= pcnt_next;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) s1 <= cmd;
    if (advance)                res <= res_next;
  end

  // Channel 1 TCSR bit 4 reads as one at all times
  assert property (@(posedge clk) disable iff (rst) tcsr[1][4])
    else $error("channel 1 TCSR bit 4 cleared");

  // Masked TCCR bits never set
  assert property (@(posedge clk) disable iff (rst)
    tccr[0][6:5] == 2'b00 && tccr[1][6:5] == 2'b00)
    else $error("TCCR reserved bits set");

  // Register accesses never raise an interrupt pulse
  assert property (@(posedge clk) disable iff (rst)
    advance && s1.op != OP_TICK |=>
      !(res.irq_match_a0 || res.irq_match_b0 || res.irq_overflow0 ||
        res.irq_match_a1 || res.irq_match_b1 || res.irq_overflow1))
    else $error("interrupt pulse on register access");

  // An error response only comes from a wide access to TCR or TCSR
  assert property (@(posedge clk) disable iff (rst)
    advance && !(s1.wide_access && s1.reg_addr[3:2] == 2'b00) |=> !res.access_error)
    else $error("spurious access error");

endmodule
